// ----- sv/nls_pkg.sv -----
// Shared types, character codes and character-class helpers for the numeric literal scanner.
package nls_pkg;

    localparam int CH_W     = 16;
    localparam int LEN_W    = 10;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    localparam logic [CH_W-1:0] CH_0       = 16'h0030;
    localparam logic [CH_W-1:0] CH_9       = 16'h0039;
    localparam logic [CH_W-1:0] CH_A_UP    = 16'h0041;
    localparam logic [CH_W-1:0] CH_F_UP    = 16'h0046;
    localparam logic [CH_W-1:0] CH_A_LO    = 16'h0061;
    localparam logic [CH_W-1:0] CH_F_LO    = 16'h0066;
    localparam logic [CH_W-1:0] CH_X_LO    = 16'h0078;
    localparam logic [CH_W-1:0] CH_DOT     = 16'h002E;
    localparam logic [CH_W-1:0] CH_E_UP    = 16'h0045;
    localparam logic [CH_W-1:0] CH_E_LO    = 16'h0065;
    localparam logic [CH_W-1:0] CH_L_UP    = 16'h004C;
    localparam logic [CH_W-1:0] CH_L_LO    = 16'h006C;
    localparam logic [CH_W-1:0] CH_MINUS   = 16'h002D;
    localparam logic [CH_W-1:0] CH_PLUS    = 16'h002B;

    localparam int USER_START_BIT = 0;
    localparam int USER_EOT_BIT   = 1;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_ZERO = 6'b000010,
        MODE_HEX  = 6'b000100,
        MODE_ZEXP = 6'b001000,
        MODE_NUM  = 6'b010000,
        MODE_SIGN = 6'b100000
    } nls_mode_t;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
    } nls_result_t;

    function automatic logic is_dec(input logic [CH_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hexd(input logic [CH_W-1:0] c);
        return is_dec(c) || ((c >= CH_A_UP) && (c <= CH_F_UP)) ||
               ((c >= CH_A_LO) && (c <= CH_F_LO));
    endfunction

    function automatic logic is_sign(input logic [CH_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_exp(input logic [CH_W-1:0] c);
        return (c == CH_E_UP) || (c == CH_E_LO);
    endfunction

    function automatic logic suffix_add(input logic have, input logic [CH_W-1:0] c,
                                        input logic allow_l);
        return have && ((c == CH_F_UP) || (c == CH_F_LO) ||
                        (allow_l && ((c == CH_L_UP) || (c == CH_L_LO))));
    endfunction

endpackage

// ----- sv/nls_core.sv -----
// Scan state registers and per-character next-state and result logic.
module nls_core import nls_pkg::*; #(
    parameter int MAX_LEN = 1023
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_en,
    input  logic [CH_W-1:0]   ch,
    input  logic              scan_start,
    input  logic              end_of_text,
    output nls_result_t       res
);

    localparam int CW = $clog2(MAX_LEN + 2);
    localparam int RW = (CW + 1 > LEN_W) ? CW + 1 : LEN_W;
    localparam logic [CW:0]   CAP     = (CW + 1)'(MAX_LEN + 1);
    localparam logic [RW-1:0] MAX_RES = RW'(MAX_LEN);

    nls_mode_t       mode_reg, mode_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]      dot_reg, dot_next;
    logic            in_exp_reg, in_exp_next;
    logic            prev_dot_reg, prev_dot_next;
    logic            prev_exp_reg, prev_exp_next;
    logic [1:0]      la_reg, la_next;

    logic            done;
    logic [RW-1:0]   raw_len;
    logic [RW-1:0]   clip_len;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [1:0] k);
        logic [CW:0] s;
        s = {1'b0, a} + (CW + 1)'(k);
        return (s > CAP) ? CAP[CW-1:0] : s[CW-1:0];
    endfunction

    function automatic logic [RW-1:0] gen_finish(input logic have, input logic [CH_W-1:0] c,
                                                 input logic [CW-1:0] cnt, input logic pdot,
                                                 input logic [1:0] dots, input logic is_sgn);
        logic [CW-1:0] core;
        logic [RW-1:0] v;
        core = pdot ? cnt - CW'(1) : cnt;
        v = RW'(core);
        if (!pdot) begin
            v = v + RW'(suffix_add(have, c, dots == 2'd0));
        end
        if (is_sgn && (core <= CW'(1))) begin
            v = '0;
        end
        return v;
    endfunction

    always_comb begin
        logic have;
        have          = !end_of_text;
        mode_next     = mode_reg;
        cnt_next      = cnt_reg;
        dot_next      = dot_reg;
        in_exp_next   = in_exp_reg;
        prev_dot_next = prev_dot_reg;
        prev_exp_next = prev_exp_reg;
        la_next       = la_reg;
        done          = 1'b0;
        raw_len       = '0;

        if (scan_start) begin
            mode_next     = MODE_IDLE;
            cnt_next      = '0;
            dot_next      = '0;
            in_exp_next   = 1'b0;
            prev_dot_next = 1'b0;
            prev_exp_next = 1'b0;
            la_next       = '0;
            if (!have) begin
                done = 1'b1;
            end else if (ch == CH_0) begin
                mode_next = MODE_ZERO;
                cnt_next  = CW'(1);
            end else if (is_dec(ch)) begin
                mode_next = MODE_NUM;
                cnt_next  = CW'(1);
            end else if (ch == CH_MINUS) begin
                mode_next = MODE_SIGN;
                cnt_next  = CW'(1);
            end else if (ch == CH_DOT) begin
                mode_next     = MODE_SIGN;
                cnt_next      = CW'(1);
                dot_next      = 2'd1;
                prev_dot_next = 1'b1;
            end else begin
                done = 1'b1;
            end
        end else begin
            unique case (mode_reg)
                MODE_IDLE: begin
                end
                MODE_ZERO: begin
                    if (have && is_dec(ch)) begin
                        mode_next = MODE_NUM;
                        cnt_next  = sat_add(cnt_reg, 2'd1);
                    end else if (have && (ch == CH_DOT)) begin
                        mode_next     = MODE_NUM;
                        cnt_next      = sat_add(cnt_reg, 2'd1);
                        dot_next      = 2'd1;
                        prev_dot_next = 1'b1;
                    end else if (have && (ch == CH_X_LO)) begin
                        mode_next = MODE_HEX;
                        cnt_next  = CW'(2);
                    end else if (have && is_exp(ch)) begin
                        mode_next     = MODE_ZEXP;
                        cnt_next      = CW'(2);
                        prev_exp_next = 1'b1;
                    end else begin
                        done    = 1'b1;
                        raw_len = RW'(1) + RW'(suffix_add(have, ch, 1'b1));
                    end
                end
                MODE_HEX: begin
                    if (have && is_hexd(ch)) begin
                        cnt_next = sat_add(cnt_reg, 2'd1);
                    end else begin
                        done    = 1'b1;
                        raw_len = (cnt_reg == CW'(2)) ? RW'(1) :
                                  RW'(cnt_reg) + RW'(suffix_add(have, ch, 1'b1));
                    end
                end
                MODE_ZEXP: begin
                    if (la_reg != 2'd0) begin
                        if (have && is_dec(ch)) begin
                            cnt_next      = sat_add(cnt_reg, 2'd2);
                            prev_exp_next = 1'b0;
                            la_next       = 2'd0;
                        end else begin
                            done    = 1'b1;
                            raw_len = (cnt_reg == CW'(2)) ? RW'(1) : RW'(cnt_reg);
                        end
                    end else if (have && is_dec(ch)) begin
                        cnt_next      = sat_add(cnt_reg, 2'd1);
                        prev_exp_next = 1'b0;
                    end else if (have && is_sign(ch) && prev_exp_reg) begin
                        la_next = 2'd1;
                    end else begin
                        done    = 1'b1;
                        raw_len = (cnt_reg == CW'(2)) ? RW'(1) :
                                  RW'(cnt_reg) + RW'(suffix_add(have, ch, 1'b1));
                    end
                end
                MODE_NUM, MODE_SIGN: begin
                    if (la_reg != 2'd0) begin
                        if (have && is_dec(ch)) begin
                            cnt_next      = sat_add(cnt_reg, la_reg + 2'd1);
                            in_exp_next   = 1'b1;
                            prev_dot_next = 1'b0;
                            la_next       = 2'd0;
                        end else if (have && (la_reg == 2'd1) && is_sign(ch)) begin
                            la_next = 2'd2;
                        end else begin
                            done    = 1'b1;
                            raw_len = gen_finish(1'b0, ch, cnt_reg, prev_dot_reg, dot_reg,
                                                 mode_reg == MODE_SIGN);
                        end
                    end else if (have && is_dec(ch)) begin
                        cnt_next      = sat_add(cnt_reg, 2'd1);
                        prev_dot_next = 1'b0;
                    end else if (have && (ch == CH_DOT) && !in_exp_reg && !prev_dot_reg) begin
                        dot_next      = (dot_reg == 2'd2) ? 2'd2 : dot_reg + 2'd1;
                        cnt_next      = sat_add(cnt_reg, 2'd1);
                        prev_dot_next = 1'b1;
                    end else if (have && is_exp(ch) && !in_exp_reg) begin
                        la_next = 2'd1;
                    end else begin
                        done    = 1'b1;
                        raw_len = gen_finish(have, ch, cnt_reg, prev_dot_reg, dot_reg,
                                             mode_reg == MODE_SIGN);
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        if (done) begin
            mode_next     = MODE_IDLE;
            cnt_next      = '0;
            dot_next      = '0;
            in_exp_next   = 1'b0;
            prev_dot_next = 1'b0;
            prev_exp_next = 1'b0;
            la_next       = '0;
        end
    end

    assign clip_len  = (raw_len > MAX_RES) ? MAX_RES : raw_len;
    assign res.valid = beat_en && done;
    assign res.len   = clip_len[LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            cnt_reg      <= '0;
            dot_reg      <= '0;
            in_exp_reg   <= 1'b0;
            prev_dot_reg <= 1'b0;
            prev_exp_reg <= 1'b0;
            la_reg       <= '0;
        end else if (beat_en) begin
            mode_reg     <= mode_next;
            cnt_reg      <= cnt_next;
            dot_reg      <= dot_next;
            in_exp_reg   <= in_exp_next;
            prev_dot_reg <= prev_dot_next;
            prev_exp_reg <= prev_exp_next;
            la_reg       <= la_next;
        end
    end

    // pending lookahead only exists inside a number or zero-exponent scan
    a_la_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (la_reg != 2'd0) |-> (mode_reg == MODE_NUM || mode_reg == MODE_SIGN ||
                              mode_reg == MODE_ZEXP))
        else $error("lookahead pending outside exponent-capable mode");

    a_dot_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        prev_dot_reg |-> ((mode_reg == MODE_NUM || mode_reg == MODE_SIGN) &&
                          cnt_reg != '0 && dot_reg != 2'd0))
        else $error("trailing dot flag inconsistent with scan state");

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, cnt_reg} <= CAP))
        else $error("character count beyond saturation cap");

endmodule

// ----- sv/nls_out_buf.sv -----
// Two-entry result buffer: output register plus skid stage.
module nls_out_buf import nls_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  nls_result_t         res,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic             out_valid_reg;
    logic [LEN_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [LEN_W-1:0] skid_data_reg;
    logic             take;

    assign take     = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - LEN_W){1'b0}}, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (out_valid_reg && !take) begin
            if (res.valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (out_valid_reg && !take) begin
            if (res.valid) begin
                skid_data_reg <= res.len;
            end
        end else if (res.valid) begin
            out_data_reg <= res.len;
        end
    end

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !skid_valid_reg)
        else $error("result arrived with both buffer entries full");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && take) |=> (out_valid_reg && !skid_valid_reg &&
                                      out_data_reg == $past(skid_data_reg)))
        else $error("skid entry not moved to output register");

endmodule

// ----- sv/numeric_literal_scanner.sv -----
// Top level of the numeric literal scanner: scan core and result buffer.
//
//  Channel  Dir  Beat contents                                  Beats
//  s_       in   tdata: ch; tuser: scan_start, end_of_text      one per character
//  m_       out  tdata: literal_length                          zero or one per character
//
//  One character per cycle while s_tready is high; the character (or end-of-text beat)
//  that ends the literal loads its length into the output register or the skid entry.
//  Scan state updates in the accept cycle; the result goes to a two-entry buffer.
//  s_tready falls only while both buffer entries hold results.
//  Synchronous active-low reset returns the scanner to idle and empties the buffer.
module numeric_literal_scanner import nls_pkg::*; #(
    parameter int MAX_LEN = 1023
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CH_W-1:0]     s_tdata,   // [15:0] ch
    input  logic [S_USER_W-1:0] s_tuser,   // [0] scan_start, [1] end_of_text
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [9:0] literal_length, rest zero
);

    nls_result_t res;
    logic        beat_en;

    assign beat_en = s_tvalid && s_tready;

    nls_core #(
        .MAX_LEN(MAX_LEN)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_en     (beat_en),
        .ch          (s_tdata),
        .scan_start  (s_tuser[USER_START_BIT]),
        .end_of_text (s_tuser[USER_EOT_BIT]),
        .res         (res)
    );

    nls_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the numeric literal scanner: stream driver, length predictor, checker.
`timescale 1ns / 100ps

module tb;
    import nls_pkg::*;

    localparam int LEN_MAX    = 1023;
    localparam int RAND_ITEMS = 700;
    localparam int HOLD_CYC   = 300;

    localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CH_W-1:0] CH_SEMI  = 16'h003B;
    localparam logic [CH_W-1:0] CH_Q_LO  = 16'h0071;
    localparam logic [CH_W-1:0] CH_Z_LO  = 16'h007A;
    localparam logic [CH_W-1:0] CH_MAXC  = 16'hFFFF;

    // Length predictor plus store of lengths still owed by the block.
    class literal_length_tracker;
        nls_mode_t        mode;
        int unsigned      cnt;
        int unsigned      dots;
        bit               in_exp;
        bit               after_dot;
        bit               after_e;
        int unsigned      pend;
        logic [LEN_W-1:0] owed_lengths[$];
        int               errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            mode      = MODE_IDLE;
            cnt       = 0;
            dots      = 0;
            in_exp    = 0;
            after_dot = 0;
            after_e   = 0;
            pend      = 0;
        endfunction

        function bit is_digit(logic [CH_W-1:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function bit is_hex_digit(logic [CH_W-1:0] c);
            return is_digit(c) || (c >= CH_A_UP && c <= CH_F_UP) ||
                   (c >= CH_A_LO && c <= CH_F_LO);
        endfunction

        function bit is_pm(logic [CH_W-1:0] c);
            return c == CH_PLUS || c == CH_MINUS;
        endfunction

        function bit is_e(logic [CH_W-1:0] c);
            return c == CH_E_UP || c == CH_E_LO;
        endfunction

        function int unsigned suffix_len(bit have, logic [CH_W-1:0] c, bit allow_l);
            if (!have)
                return 0;
            if (c == CH_F_UP || c == CH_F_LO)
                return 1;
            if (allow_l && (c == CH_L_UP || c == CH_L_LO))
                return 1;
            return 0;
        endfunction

        function int unsigned sat_add(int unsigned a, int unsigned k);
            return (a + k > LEN_MAX + 1) ? LEN_MAX + 1 : a + k;
        endfunction

        function int unsigned finish_len(bit have, logic [CH_W-1:0] c);
            int unsigned core;
            int unsigned v;
            core = after_dot ? cnt - 1 : cnt;
            v = core;
            if (!after_dot)
                v += suffix_len(have, c, dots == 0);
            if (mode == MODE_SIGN && core <= 1)
                v = 0;
            return v;
        endfunction

        // decimal / dotted / exponent loop; 1 when the literal has ended
        function bit decimal_step(bit have, logic [CH_W-1:0] c, output int unsigned res);
            res = 0;
            if (pend != 0) begin
                if (have && is_digit(c)) begin
                    cnt = sat_add(cnt, pend + 1);
                    in_exp = 1;
                    after_dot = 0;
                    pend = 0;
                    return 0;
                end
                if (have && pend == 1 && is_pm(c)) begin
                    pend = 2;
                    return 0;
                end
                res = finish_len(0, c);
                return 1;
            end
            if (!have) begin
                res = finish_len(0, c);
                return 1;
            end
            if (is_digit(c)) begin
                cnt = sat_add(cnt, 1);
                after_dot = 0;
                return 0;
            end
            if (c == CH_DOT && !in_exp && !after_dot) begin
                if (dots < 2)
                    dots++;
                cnt = sat_add(cnt, 1);
                after_dot = 1;
                return 0;
            end
            if (is_e(c) && !in_exp) begin
                pend = 1;
                return 0;
            end
            res = finish_len(1, c);
            return 1;
        endfunction

        function logic [LEN_W-1:0] clip(int unsigned v);
            int unsigned m;
            m = (v > LEN_MAX) ? LEN_MAX : v;
            return m[LEN_W-1:0];
        endfunction

        function void note_char(logic [CH_W-1:0] c, bit start, bit eot);
            bit          have;
            bit          done;
            int unsigned r;
            have = !eot;
            done = 0;
            r = 0;
            if (start) begin
                clear();
                if (!have) begin
                    owed_lengths.push_back('0);
                end else if (c == CH_0) begin
                    mode = MODE_ZERO;
                    cnt = 1;
                end else if (is_digit(c)) begin
                    mode = MODE_NUM;
                    cnt = 1;
                end else if (c == CH_MINUS) begin
                    mode = MODE_SIGN;
                    cnt = 1;
                end else if (c == CH_DOT) begin
                    mode = MODE_SIGN;
                    cnt = 1;
                    dots = 1;
                    after_dot = 1;
                end else begin
                    owed_lengths.push_back('0);
                end
                return;
            end
            case (mode)
                MODE_ZERO: begin
                    if (have && (is_digit(c) || c == CH_DOT)) begin
                        mode = MODE_NUM;
                        done = decimal_step(have, c, r);
                    end else if (have && c == CH_X_LO) begin
                        mode = MODE_HEX;
                        cnt = 2;
                    end else if (have && is_e(c)) begin
                        mode = MODE_ZEXP;
                        cnt = 2;
                        after_e = 1;
                    end else begin
                        r = 1 + suffix_len(have, c, 1);
                        done = 1;
                    end
                end
                MODE_HEX: begin
                    if (have && is_hex_digit(c)) begin
                        cnt = sat_add(cnt, 1);
                    end else begin
                        r = (cnt == 2) ? 1 : cnt + suffix_len(have, c, 1);
                        done = 1;
                    end
                end
                MODE_ZEXP: begin
                    if (pend != 0) begin
                        if (have && is_digit(c)) begin
                            cnt = sat_add(cnt, 2);
                            after_e = 0;
                            pend = 0;
                        end else begin
                            r = (cnt == 2) ? 1 : cnt;
                            done = 1;
                        end
                    end else if (have && is_digit(c)) begin
                        cnt = sat_add(cnt, 1);
                        after_e = 0;
                    end else if (have && is_pm(c) && after_e) begin
                        pend = 1;
                    end else begin
                        r = (cnt == 2) ? 1 : cnt + suffix_len(have, c, 1);
                        done = 1;
                    end
                end
                MODE_NUM, MODE_SIGN: begin
                    done = decimal_step(have, c, r);
                end
                default: begin
                    return;
                end
            endcase
            if (done) begin
                owed_lengths.push_back(clip(r));
                clear();
            end
        endfunction

        function void check_len(logic [M_DATA_W-1:0] d);
            logic [LEN_W-1:0] want;
            if (owed_lengths.size() == 0) begin
                $error("unexpected length beat: literal_length %0d", d[LEN_W-1:0]);
                errors++;
                return;
            end
            want = owed_lengths.pop_front();
            if (d[LEN_W-1:0] !== want) begin
                $error("literal_length: expected %0d, got %0d", want, d[LEN_W-1:0]);
                errors++;
            end
            if (d[M_DATA_W-1:LEN_W] !== '0) begin
                $error("tdata pad: expected 0, got 'h%0h", d[M_DATA_W-1:LEN_W]);
                errors++;
            end
        endfunction

        function int owed();
            return owed_lengths.size();
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CH_W-1:0]     s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    literal_length_tracker tracker = new();
    bit no_idle  = 0;
    bit hold_req = 0;
    int rand_count = 0;

    numeric_literal_scanner #(.MAX_LEN(LEN_MAX)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic send_beat(input logic [CH_W-1:0] c, input bit st = 0, input bit et = 0);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= {et, st};
        do @(posedge aclk); while (!s_tready);
        tracker.note_char(c, st, et);
        rand_count++;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.owed() > 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    function automatic logic [CH_W-1:0] body_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CH_0 + CH_W'($urandom_range(0, 9));
        if (r < 55) return CH_DOT;
        if (r < 62) return $urandom_range(0, 1) ? CH_E_LO : CH_E_UP;
        if (r < 70) return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        if (r < 75) return CH_X_LO;
        if (r < 83)
            return ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + CH_W'($urandom_range(0, 5));
        if (r < 90) return suffix_char();
        return CH_SPACE;
    endfunction

    function automatic logic [CH_W-1:0] suffix_char();
        case ($urandom_range(0, 3))
            0: return CH_F_UP;
            1: return CH_F_LO;
            2: return CH_L_UP;
            default: return CH_L_LO;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] start_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return CH_0;
        if (r < 70) return CH_0 + CH_W'($urandom_range(1, 9));
        if (r < 85) return CH_MINUS;
        return CH_DOT;
    endfunction

    task automatic random_literal();
        int n;
        int r;
        logic [CH_W-1:0] first;
        first = start_char();
        send_beat(first, 1);
        if (first == CH_0 && $urandom_range(0, 1))
            send_beat($urandom_range(0, 1) ? CH_X_LO : CH_E_LO);
        n = $urandom_range(0, 8);
        repeat (n) send_beat(body_char());
        r = $urandom_range(0, 99);
        if (r < 12) send_beat(CH_SPACE, 0, 1);
        else if (r < 22) ;
        else if (r < 40) send_beat(suffix_char());
        else if (r < 60) send_beat(CH_SPACE);
        else if (r < 75) send_beat(CH_W'($urandom_range(0, 127)));
        else send_beat(CH_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) send_beat(CH_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 1))
                send_beat(CH_W'($urandom_range(0, 65535)), 0, 1);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_len(m_tdata);
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int run;
        int stall;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_req = 0;
            end else begin
                run = $urandom_range(1, 12);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: bare sign/dot, empty hex and exponent, failed exponent, odd starts, suffixes
        send_beat(CH_MINUS, 1);  send_beat(CH_SPACE, 0, 1);
        send_beat(CH_DOT, 1);    send_beat(CH_SPACE);
        send_beat(CH_MINUS, 1);  send_beat(CH_DOT);  send_beat(CH_SPACE);
        send_beat(CH_0, 1);      send_beat(CH_X_LO); send_beat(CH_SEMI);
        send_beat(CH_0, 1);      send_beat(CH_E_UP); send_beat(CH_PLUS); send_beat(CH_SPACE);
        send_beat(CH_0 + 1, 1);  send_beat(CH_E_LO); send_beat(CH_MINUS); send_beat(CH_X_LO);
        send_beat(CH_Z_LO, 1);
        send_beat(CH_MAXC, 1, 1);
        send_beat(CH_0 + 9, 1);  send_beat(CH_0 + 7, 1); send_beat(CH_F_LO);
        send_beat(CH_Q_LO);      send_beat(CH_MAXC, 0, 1);
        send_beat(CH_0 + 1, 1);  send_beat(CH_DOT);  send_beat(CH_0 + 2); send_beat(CH_L_UP);
        drain();

        // saturation: overlong number ending in a trailing dot at the cap
        send_beat(CH_0 + 3, 1);
        repeat (1025) send_beat(CH_0 + CH_W'($urandom_range(0, 9)));
        send_beat(CH_DOT);
        send_beat(CH_SPACE, 0, 1);
        drain();

        // fill the result buffer while the receiver holds off
        hold_req = 1;
        no_idle = 1;
        repeat (40) begin
            send_beat(CH_0 + CH_W'($urandom_range(1, 9)), 1);
            send_beat(CH_SPACE);
        end
        no_idle = 0;
        drain();

        rand_count = 0;
        while (rand_count < RAND_ITEMS) begin
            no_idle = (rand_count > 250 && rand_count < 350);
            if ($urandom_range(0, 99) < 85)
                random_literal();
            else
                send_beat(CH_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            if (rand_count > 400 && rand_count < 415)
                drain();
        end
        no_idle = 0;
        drain();
        repeat (20) @(posedge aclk);

        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
